FILE: rtl/ptid_pkg.sv
`default_nettype none

package ptid_pkg;

  // Request operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 7;
  localparam int DIM_W   = 8;
  localparam int PIX_W   = 4;

  // Bit width of the byte size of one image: (width/2) * height.
  localparam int SIZE_W = (DIM_W - 1) + DIM_W;

  // Width drops its low three bits, height its low two.
  localparam logic [DIM_W-1:0] WIDTH_MASK  = 8'hf8;
  localparam logic [DIM_W-1:0] HEIGHT_MASK = 8'hfc;

  // Nibble selects within a raw byte.
  localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hf0;
  localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0f;

  // Tag of a memory read in flight: whether its data returns on the next cycle
  // and which plane it feeds.
  typedef struct packed {
    logic       pend;
    logic [1:0] plane;
  } rd_tag_t;

endpackage

`default_nettype wire

FILE: rtl/planar_tile_image_decoder.sv
// Planar tile image store. A load request writes one raw byte (two 4-bit
// pixels, high nibble first) at the running load address, which wraps after
// (width/2)*height bytes; a load leaves the block idle and gives no result. A read
// request returns one decoded 4-bit pixel index built from one bit of each of
// four stored pixels, so it issues four reads on the single-port byte memory,
// one per cycle: an in-range read passes through the accept, four memory reads,
// a drain state for the read latency and a posting state, and an out-of-range
// read goes from the accept straight to posting, answering 0. A finished
// result waits in the output register while the next request is taken; the
// next read then holds in its posting state until that result is taken.
// Configuration writes are taken every cycle and must only come while the
// block is idle. The memory needs no clearing after reset; reading bytes never
// loaded gives undefined pixel values.
`default_nettype none

module planar_tile_image_decoder import ptid_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_operation,
  input  wire  [BYTE_W-1:0]      in_raw_byte,
  input  wire  [COORD_W-1:0]     in_pixel_row,
  input  wire  [COORD_W-1:0]     in_pixel_col,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [PIX_W-1:0]       out_pixel_index,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [DIM_W-1:0]       cfg_data
);

  localparam int DEPTH = (MAX_WIDTH / 2) * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int W_CAP = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int H_CAP = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam logic [DIM_W-1:0] W_RST = DIM_W'((MAX_WIDTH < 16) ? MAX_WIDTH : 16) & WIDTH_MASK;
  localparam logic [DIM_W-1:0] H_RST =
    DIM_W'((MAX_HEIGHT < 16) ? MAX_HEIGHT : 16) & HEIGHT_MASK;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  rd_tag_t           tag_r, tag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [AW-1:0]     load_addr_r, load_addr_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;

  logic [DIM_W-1:0]  row_r, col_r;
  logic [1:0]        k_r;
  logic [PIX_W-1:0]  acc_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic [BYTE_W-1:0] rd_data_r;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic              in_acc, load_acc, read_acc, in_range, out_free, rd_issue;
  logic [SIZE_W:0]   rd_addr_full;
  logic [AW-1:0]     mem_addr;
  logic [SIZE_W-1:0] img_size;
  logic [CW-1:0]     ld_inc;
  logic [DIM_W-1:0]  col_start, row_start;
  logic [PIX_W-1:0]  nibble;
  logic              plane_bit;

  // Request handshake decode.
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && (in_operation == OP_LOAD);
  assign read_acc  = in_acc && (in_operation == OP_READ);
  assign out_free  = !out_valid_r || out_ready;
  assign rd_issue  = (state_r == S_READ);

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pixel_r;

  // Read setup: range check and the sub-image coordinates of the first plane.
  assign in_range  = ({1'b0, in_pixel_row} < height_r) && ({1'b0, in_pixel_col} < width_r);
  assign col_start = DIM_W'({2'b0, width_r[DIM_W-1:2]} * {6'b0, in_pixel_row[1:0]})
                   + {3'b0, in_pixel_col[COORD_W-1:2]};
  assign row_start = {3'b0, in_pixel_row[COORD_W-1:2]};

  // Byte address of the stored pixel for the current plane.
  assign rd_addr_full = (SIZE_W + 1)'({8'b0, row_r} * {9'b0, width_r[DIM_W-1:1]})
                      + {9'b0, col_r[DIM_W-1:1]};
  assign mem_addr = rd_issue ? AW'(rd_addr_full) : load_addr_r;

  // Load address advance with wrap at one image.
  assign img_size = {8'b0, width_r[DIM_W-1:1]} * {7'b0, height_r};
  assign ld_inc   = CW'(load_addr_r) + CW'(1);

  // Pick the nibble of the stored pixel, then the bit of this column phase.
  assign nibble    = col_r[0] ? PIX_W'((rd_data_r & LO_NIBBLE))
                              : PIX_W'((rd_data_r & HI_NIBBLE) >> PIX_W);
  assign plane_bit = nibble[2'd3 - k_r];

  // Sequencer and control next state.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tag_nxt.pend  = rd_issue;
    tag_nxt.plane = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_addr_nxt = load_addr_r;
    width_nxt     = width_r;
    height_nxt    = height_r;

    if (load_acc) begin
      load_addr_nxt = (ld_inc >= CW'(img_size)) ? '0 : AW'(ld_inc);
    end

    unique case (state_r)
      S_IDLE: begin
        if (read_acc) begin
          cnt_nxt   = 2'd0;
          state_nxt = in_range ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_nxt = ((int'(cfg_data) > W_CAP) ? DIM_W'(W_CAP) : cfg_data) & WIDTH_MASK;
        end
        CFG_IMAGE_HEIGHT: begin
          height_nxt = ((int'(cfg_data) > H_CAP) ? DIM_W'(H_CAP) : cfg_data) & HEIGHT_MASK;
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
      load_addr_r <= '0;
      width_r     <= W_RST;
      height_r    <= H_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
      load_addr_r <= load_addr_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  // Read working registers and result gathering.
  always_ff @(posedge clk) begin
    if (read_acc) begin
      row_r <= row_start;
      col_r <= col_start;
      k_r   <= in_pixel_col[1:0];
      acc_r <= '0;
    end else if (rd_issue) begin
      row_r <= row_r + {2'b0, height_r[DIM_W-1:2]};
    end
    if (tag_r.pend) begin
      acc_r[tag_r.plane] <= plane_bit;
    end
    if (state_r == S_DONE && out_free) begin
      out_pixel_r <= acc_r;
    end
  end

  // Single-port raw byte memory.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[mem_addr] <= in_raw_byte;
    end
    if (rd_issue) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Read data only returns while a decode is in flight.
  a_pend_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.pend |-> (state_r == S_READ || state_r == S_DRAIN))
    else $error("read data returned outside a decode");

  // A read request always occupies the sequencer on the next cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    read_acc |=> (state_r != S_IDLE))
    else $error("read request did not start a decode");

  // A load either advances the address by one or wraps it to zero.
  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (load_addr_r == '0 || load_addr_r == $past(load_addr_r) + AW'(1)))
    else $error("load address stepped wrongly");

endmodule

`default_nettype wire
